// ===== sv/gf2_192_multiply_accumulate_defines.svh =====
// ----------------------------------------------------------------------------
// GF(2^192) multiply-accumulate assertion macros
// Shared assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GF2_192_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define GF2_192_MULTIPLY_ACCUMULATE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GF2M_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define GF2M_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GF2M_ASSERT(lbl, expr, msg)
`define GF2M_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/gf2m_pkg.sv =====
// ----------------------------------------------------------------------------
// GF(2^192) multiply-accumulate package
// Operation codes, field constants and carry-less arithmetic helpers.
// ----------------------------------------------------------------------------
package gf2m_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned NUM_W   = 3;
    localparam int unsigned FIELD_W = WORD_W * NUM_W;
    localparam int unsigned PROD_W  = 2 * FIELD_W - 1;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_MUL    = 2'd1;
    localparam logic [1:0] CMD_MAC    = 2'd2;
    localparam logic [1:0] CMD_SQUARE = 2'd3;

    // Low part of the reduction polynomial x^192 + x^7 + x^2 + x + 1.
    localparam logic [7:0] POLY_LOW = 8'h87;

    typedef logic [NUM_W-1:0][WORD_W-1:0] elem_t;
    typedef logic [PROD_W-1:0]            prod_t;

    function automatic logic [2*WORD_W-2:0] clmul64(input logic [WORD_W-1:0] x,
                                                    input logic [WORD_W-1:0] y);
        logic [2*WORD_W-2:0] acc;
        acc = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (y[i])
            begin
                acc = acc ^ ({{(WORD_W-1){1'b0}}, x} << i);
            end
        end
        return acc;
    endfunction

    function automatic prod_t clmul192(input elem_t x, input elem_t y);
        prod_t acc;
        acc = '0;
        for (int i = 0; i < NUM_W; i++)
        begin
            for (int j = 0; j < NUM_W; j++)
            begin
                acc = acc ^ ({{(PROD_W-2*WORD_W+1){1'b0}}, clmul64(x[i], y[j])}
                             << (WORD_W * (i + j)));
            end
        end
        return acc;
    endfunction

    function automatic elem_t reduce(input prod_t p);
        logic [FIELD_W-1:0]   h;
        logic [FIELD_W+6:0]   t;
        logic [6:0]           o;
        logic [13:0]          u;
        h = {1'b0, p[PROD_W-1:FIELD_W]};
        t = '0;
        u = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (POLY_LOW[i])
            begin
                t = t ^ ({7'd0, h} << i);
            end
        end
        o = t[FIELD_W+6:FIELD_W];
        for (int i = 0; i < 8; i++)
        begin
            if (POLY_LOW[i])
            begin
                u = u ^ ({7'd0, o} << i);
            end
        end
        return p[FIELD_W-1:0] ^ t[FIELD_W-1:0] ^ {{(FIELD_W-14){1'b0}}, u};
    endfunction

endpackage

// ===== sv/gf2m_in_if.sv =====
// ----------------------------------------------------------------------------
// GF(2^192) operation channel
// Valid/ready channel carrying the operation code and three operands.
// ----------------------------------------------------------------------------
interface gf2m_in_if;

    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] a_w0;
    logic [63:0] a_w1;
    logic [63:0] a_w2;
    logic [63:0] b_w0;
    logic [63:0] b_w1;
    logic [63:0] b_w2;
    logic [63:0] acc_w0;
    logic [63:0] acc_w1;
    logic [63:0] acc_w2;

    modport source (
        output valid, cmd, a_w0, a_w1, a_w2, b_w0, b_w1, b_w2, acc_w0, acc_w1, acc_w2,
        input  ready
    );

    modport sink (
        input  valid, cmd, a_w0, a_w1, a_w2, b_w0, b_w1, b_w2, acc_w0, acc_w1, acc_w2,
        output ready
    );

endinterface

// ===== sv/gf2m_out_if.sv =====
// ----------------------------------------------------------------------------
// GF(2^192) result channel
// Valid/ready channel carrying one reduced 192-bit field element.
// ----------------------------------------------------------------------------
interface gf2m_out_if;

    logic        valid;
    logic        ready;
    logic [63:0] res_w0;
    logic [63:0] res_w1;
    logic [63:0] res_w2;

    modport source (
        output valid, res_w0, res_w1, res_w2,
        input  ready
    );

    modport sink (
        input  valid, res_w0, res_w1, res_w2,
        output ready
    );

endinterface

// ===== sv/gf2_192_multiply_accumulate.sv =====
// ----------------------------------------------------------------------------
// GF(2^192) multiply-accumulate unit
// Pipelined add, multiply, multiply-accumulate and square over GF(2^192).
// ----------------------------------------------------------------------------
// Operation words arrive on the operands channel and one reduced result word
// per operation leaves on the results channel, both valid/ready handshakes.
// The pipeline has three register stages: operand capture, the 383-bit
// carry-less product formed from nine 64x64 partial products, and the
// reduction by x^192 + x^7 + x^2 + x + 1 followed by the final xor.
// An accepted word moves through the operand, product and result stages in
// turn, and the result stage register drives the results channel.
// Unless stalled, one word enters each cycle, a rate set by the full product array.
// When the receiver stalls, each stage holds its word while the stages behind
// it keep filling bubbles, so ready drops only once all three stages are full.
// Nothing is lost or repeated across a stall.
// Reset clears the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`include "gf2_192_multiply_accumulate_defines.svh"

module gf2_192_multiply_accumulate (
    input  logic       clk,
    input  logic       rst_n,
    gf2m_in_if.sink    operands,
    gf2m_out_if.source results
);

    logic                v1_reg;
    logic                mul1_reg;
    gf2m_pkg::elem_t     a1_reg;
    gf2m_pkg::elem_t     b1_reg;
    gf2m_pkg::elem_t     lin1_reg;

    logic                v2_reg;
    logic                mul2_reg;
    gf2m_pkg::prod_t     prod2_reg;
    gf2m_pkg::elem_t     lin2_reg;

    logic                v3_reg;
    gf2m_pkg::elem_t     res3_reg;

    logic                ready1;
    logic                ready2;
    logic                ready3;

    gf2m_pkg::elem_t     a_in;
    gf2m_pkg::elem_t     b_in;
    gf2m_pkg::elem_t     acc_in;
    gf2m_pkg::elem_t     b1_next;
    gf2m_pkg::elem_t     lin1_next;
    logic                mul1_next;
    gf2m_pkg::prod_t     prod2_next;
    gf2m_pkg::elem_t     res3_next;

    assign ready3 = !v3_reg || results.ready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign operands.ready = ready1;

    assign a_in   = {operands.a_w2, operands.a_w1, operands.a_w0};
    assign b_in   = {operands.b_w2, operands.b_w1, operands.b_w0};
    assign acc_in = {operands.acc_w2, operands.acc_w1, operands.acc_w0};

    // The linear term is a xor b for add, the accumulator for multiply-accumulate,
    // and zero otherwise; the product term is added in the last stage.
    always_comb
    begin
        b1_next   = b_in;
        lin1_next = '0;
        mul1_next = 1'b1;
        case (operands.cmd)
            gf2m_pkg::CMD_ADD:
            begin
                lin1_next = a_in ^ b_in;
                mul1_next = 1'b0;
            end
            gf2m_pkg::CMD_MUL:
            begin
                lin1_next = '0;
            end
            gf2m_pkg::CMD_MAC:
            begin
                lin1_next = acc_in;
            end
            gf2m_pkg::CMD_SQUARE:
            begin
                b1_next = a_in;
            end
            default:
            begin
                lin1_next = '0;
            end
        endcase
    end

    assign prod2_next = gf2m_pkg::clmul192(a1_reg, b1_reg);
    assign res3_next  = (mul2_reg ? gf2m_pkg::reduce(prod2_reg) : '0) ^ lin2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= operands.valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && operands.valid)
        begin
            mul1_reg <= mul1_next;
            a1_reg   <= a_in;
            b1_reg   <= b1_next;
            lin1_reg <= lin1_next;
        end
        if (ready2 && v1_reg)
        begin
            mul2_reg  <= mul1_reg;
            prod2_reg <= prod2_next;
            lin2_reg  <= lin1_reg;
        end
        if (ready3 && v2_reg)
        begin
            res3_reg <= res3_next;
        end
    end

    assign results.valid  = v3_reg;
    assign results.res_w0 = res3_reg[0];
    assign results.res_w1 = res3_reg[1];
    assign results.res_w2 = res3_reg[2];

    `GF2M_ASSERT(a_ready_chain, operands.ready == (!v1_reg || !v2_reg || !v3_reg || results.ready), "input ready does not follow pipeline occupancy")
    `GF2M_ASSERT_NEXT(a_stage2_hold, v2_reg && !ready3, v2_reg && $stable(prod2_reg) && $stable(lin2_reg), "stalled product stage changed")
    `GF2M_ASSERT_NEXT(a_stage1_hold, v1_reg && !ready2, v1_reg && $stable(a1_reg) && $stable(b1_reg), "stalled operand stage changed")

endmodule
